// File: rtl/wels_pkg.sv
package wels_pkg;

    // default number of phase slots
    localparam int NUM_PHASES_DEF = 16;

    // queue between front and back
    localparam int QDEPTH = 2;

    // input opcodes
    localparam logic OP_PHASE = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // output record kinds
    localparam logic REC_SUMMARY = 1'b0;
    localparam logic REC_PHASE   = 1'b1;

    // register indexes (8-byte stride)
    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_THRESH   = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    localparam int ADDR_W = 5;

    // register reset values
    localparam logic        ENABLE_RST   = 1'b1;
    localparam logic [47:0] THRESH_RST   = 48'd25000;
    localparam logic [47:0] INTERVAL_RST = 48'd30000000;

    // frame time limits in microseconds
    localparam logic [23:0] FRAME_LIMIT_US = 24'd10000000;
    localparam logic [23:0] HITCH_25_US    = 24'd25000;
    localparam logic [23:0] HITCH_50_US    = 24'd50000;
    localparam logic [23:0] HITCH_100_US   = 24'd100000;

    // classified work item, front to back
    typedef struct packed {
        logic        kind;
        logic [5:0]  phase;
        logic [47:0] dur;
        logic [31:0] units;
        logic [23:0] ftime;
        logic [2:0]  hitch;
        logic [47:0] now;
    } t_work;

    // one phase table entry
    typedef struct packed {
        logic [47:0] calls;
        logic [47:0] slow;
        logic [47:0] total;
        logic [47:0] tmax;
        logic [47:0] units;
    } t_phase_stats;

    // one outgoing record
    typedef struct packed {
        logic        record_kind;
        logic [5:0]  phase_number;
        logic [47:0] event_count;
        logic [47:0] slow_count;
        logic [47:0] total_time;
        logic [47:0] max_time;
        logic [47:0] units_total;
        logic [47:0] elapsed_ticks;
        logic [47:0] hitch_25;
        logic [47:0] hitch_50;
        logic [47:0] hitch_100;
        logic        last_of_report;
    } t_record;

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

endpackage

// File: rtl/wels_event_if.sv
interface wels_event_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [5:0]  phase_index;
    logic [47:0] duration_ticks;
    logic [31:0] unit_count;
    logic [23:0] frame_time_us;
    logic [47:0] timestamp;

    modport source (
        output valid, opcode, phase_index, duration_ticks, unit_count,
               frame_time_us, timestamp,
        input  ready
    );
    modport sink (
        input  valid, opcode, phase_index, duration_ticks, unit_count,
               frame_time_us, timestamp,
        output ready
    );
endinterface

// File: rtl/wels_record_if.sv
interface wels_record_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic [5:0]  phase_number;
    logic [47:0] event_count;
    logic [47:0] slow_count;
    logic [47:0] total_time;
    logic [47:0] max_time;
    logic [47:0] units_total;
    logic [47:0] elapsed_ticks;
    logic [47:0] hitch_25;
    logic [47:0] hitch_50;
    logic [47:0] hitch_100;
    logic        last_of_report;

    modport source (
        output valid, record_kind, phase_number, event_count, slow_count,
               total_time, max_time, units_total, elapsed_ticks,
               hitch_25, hitch_50, hitch_100, last_of_report,
        input  ready
    );
    modport sink (
        input  valid, record_kind, phase_number, event_count, slow_count,
               total_time, max_time, units_total, elapsed_ticks,
               hitch_25, hitch_50, hitch_100, last_of_report,
        output ready
    );
endinterface

// File: rtl/windowed_event_latency_statistics_core.sv
// Channel   Dir  Beat                                          Handshake
// i_evt     in   one phase or frame event                      valid/ready
// o_rec     out  frame summary or phase record (report)        valid/ready
// apb       in   register write/read, 8-byte stride, 64b data  psel/penable, pready=1
//
// Phase event: the back end reads, then writes back the phase table (the RAM has
//   separate read and write ports). Frame event: update, then window check.
// A report adds a summary record, then a table read per phase record; an output stall holds it.
// The front takes a beat every cycle while the 2-deep work queue has room;
//   a stalled output register holds the back end, not the front.
// Reset clears control state and table valid bits, and loads register defaults.
module windowed_event_latency_statistics_core #(
    parameter int NUM_PHASES = wels_pkg::NUM_PHASES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    wels_event_if.sink                  i_evt,
    wels_record_if.source               o_rec,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wels_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);

    // config registers
    logic        r_enable;
    logic [47:0] r_slow_threshold;
    logic [47:0] r_report_interval;

    logic [1:0]  reg_idx;
    logic        cfg_wr;

    // front <-> queue <-> back
    logic            push;
    wels_pkg::t_work push_item;
    logic            q_full;
    logic            q_valid;
    wels_pkg::t_work q_item;
    logic            q_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable          <= wels_pkg::ENABLE_RST;
            r_slow_threshold  <= wels_pkg::THRESH_RST;
            r_report_interval <= wels_pkg::INTERVAL_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                wels_pkg::REG_ENABLE:   r_enable          <= pwdata[0];
                wels_pkg::REG_THRESH:   r_slow_threshold  <= pwdata[47:0];
                wels_pkg::REG_INTERVAL: r_report_interval <= pwdata[47:0];
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            wels_pkg::REG_ENABLE:   prdata = {63'd0, r_enable};
            wels_pkg::REG_THRESH:   prdata = {16'd0, r_slow_threshold};
            wels_pkg::REG_INTERVAL: prdata = {16'd0, r_report_interval};
            default:                prdata = '0;
        endcase
    end

    // front: filter disabled and out-of-range events, normalize frame time
    wels_front #(
        .NUM_PHASES (NUM_PHASES)
    ) u_front (
        .i_evt    (i_evt),
        .i_enable (r_enable),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (push_item)
    );

    wels_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // back: table read-modify-write, frame stats, report drain
    wels_back #(
        .NUM_PHASES (NUM_PHASES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_slow_threshold  (r_slow_threshold),
        .i_report_interval (r_report_interval),
        .i_q_valid         (q_valid),
        .i_q_item          (q_item),
        .o_q_pop           (q_pop),
        .o_rec             (o_rec)
    );

endmodule

// File: rtl/wels_ram.sv
module wels_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/wels_fifo.sv
module wels_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wels_pkg::t_work   i_item,
    output logic              o_full,
    output logic              o_valid,
    output wels_pkg::t_work   o_item,
    input  logic              i_pop
);

    localparam int PTR_W = (wels_pkg::QDEPTH > 1) ? $clog2(wels_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(wels_pkg::QDEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(wels_pkg::QDEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(wels_pkg::QDEPTH);

    wels_pkg::t_work r_mem [wels_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wptr] <= i_item;
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/wels_front.sv
module wels_front #(
    parameter int NUM_PHASES = wels_pkg::NUM_PHASES_DEF
) (
    wels_event_if.sink      i_evt,
    input  logic            i_enable,
    input  logic            i_q_full,
    output logic            o_push,
    output wels_pkg::t_work o_item
);

    localparam logic [5:0] PH_LIMIT = 6'(NUM_PHASES);

    logic        keep;
    logic [23:0] ftime;

    // out-of-range frame times count as zero
    assign ftime = (i_evt.frame_time_us >= wels_pkg::FRAME_LIMIT_US) ? '0
                                                                    : i_evt.frame_time_us;

    // drop disabled events and phases past the table
    assign keep = i_enable &&
                  ((i_evt.opcode == wels_pkg::OP_FRAME) || (i_evt.phase_index < PH_LIMIT));

    assign i_evt.ready = !i_q_full;
    assign o_push      = i_evt.valid && !i_q_full && keep;

    always_comb begin
        o_item.kind     = i_evt.opcode;
        o_item.phase    = i_evt.phase_index;
        o_item.dur      = i_evt.duration_ticks;
        o_item.units    = i_evt.unit_count;
        o_item.ftime    = ftime;
        o_item.hitch[0] = (ftime >= wels_pkg::HITCH_25_US);
        o_item.hitch[1] = (ftime >= wels_pkg::HITCH_50_US);
        o_item.hitch[2] = (ftime >= wels_pkg::HITCH_100_US);
        o_item.now      = i_evt.timestamp;
    end

endmodule

// File: rtl/wels_back.sv
module wels_back #(
    parameter int NUM_PHASES = wels_pkg::NUM_PHASES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [47:0]     i_slow_threshold,
    input  logic [47:0]     i_report_interval,
    input  logic            i_q_valid,
    input  wels_pkg::t_work i_q_item,
    output logic            o_q_pop,
    wels_record_if.source   o_rec
);

    localparam int IDX_W = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PHASES - 1);
    localparam int SW = $bits(wels_pkg::t_phase_stats);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PHASE,
        S_FRAME,
        S_CHECK,
        S_SUM,
        S_RD,
        S_REC
    } t_state;

    t_state                 r_state;
    wels_pkg::t_work        r_item;
    logic [IDX_W-1:0]       r_idx;
    logic [NUM_PHASES-1:0]  r_valid;
    logic [47:0]            r_frame_count;
    logic [47:0]            r_frame_sum;
    logic [23:0]            r_frame_max;
    logic [47:0]            r_hitch [3];
    logic [47:0]            r_window_start;
    logic [47:0]            r_window_end;
    logic [47:0]            r_elapsed;
    logic                   r_out_valid;
    wels_pkg::t_record      r_out;

    logic [IDX_W-1:0]       ram_raddr;
    logic [SW-1:0]          ram_q;
    logic                   ram_we;
    wels_pkg::t_phase_stats cur;
    wels_pkg::t_phase_stats n_stats;
    logic                   out_free;
    logic                   out_load;

    // table read: head of queue while idle, else the working slot
    assign ram_raddr = (r_state == S_IDLE) ? i_q_item.phase[IDX_W-1:0] : r_idx;
    assign ram_we    = (r_state == S_PHASE);

    wels_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_PHASES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (n_stats),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // never-written slots read as zero
    assign cur = r_valid[r_idx] ? wels_pkg::t_phase_stats'(ram_q) : '0;

    always_comb begin
        n_stats.calls = wels_pkg::sat_add48(cur.calls, 48'd1);
        n_stats.total = wels_pkg::sat_add48(cur.total, r_item.dur);
        n_stats.units = wels_pkg::sat_add48(cur.units, {16'd0, r_item.units});
        n_stats.slow  = (r_item.dur >= i_slow_threshold)
                        ? wels_pkg::sat_add48(cur.slow, 48'd1) : cur.slow;
        n_stats.tmax  = (r_item.dur > cur.tmax) ? r_item.dur : cur.tmax;
    end

    assign out_free = !r_out_valid || o_rec.ready;
    assign out_load = ((r_state == S_SUM) || (r_state == S_REC)) && out_free;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_idx          <= '0;
            r_valid        <= '0;
            r_frame_count  <= '0;
            r_frame_sum    <= '0;
            r_frame_max    <= '0;
            r_hitch[0]     <= '0;
            r_hitch[1]     <= '0;
            r_hitch[2]     <= '0;
            r_window_start <= '0;
            r_window_end   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rec.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_item;
                        r_idx   <= i_q_item.phase[IDX_W-1:0];
                        r_state <= (i_q_item.kind == wels_pkg::OP_FRAME) ? S_FRAME : S_PHASE;
                    end
                end
                S_PHASE: begin
                    r_valid[r_idx] <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_FRAME: begin
                    if (r_window_start == '0) begin
                        r_window_start <= r_item.now;
                        r_window_end   <= wels_pkg::sat_add48(r_item.now, i_report_interval);
                    end
                    r_frame_count <= wels_pkg::sat_add48(r_frame_count, 48'd1);
                    r_frame_sum   <= wels_pkg::sat_add48(r_frame_sum, {24'd0, r_item.ftime});
                    if (r_item.ftime > r_frame_max) begin
                        r_frame_max <= r_item.ftime;
                    end
                    for (int h = 0; h < 3; h++) begin
                        if (r_item.hitch[h]) begin
                            r_hitch[h] <= wels_pkg::sat_add48(r_hitch[h], 48'd1);
                        end
                    end
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_elapsed <= r_item.now - r_window_start;
                    r_state   <= (r_item.now >= r_window_end) ? S_SUM : S_IDLE;
                end
                S_SUM: begin
                    if (out_free) begin
                        r_out.record_kind    <= wels_pkg::REC_SUMMARY;
                        r_out.phase_number   <= '0;
                        r_out.event_count    <= r_frame_count;
                        r_out.slow_count     <= '0;
                        r_out.total_time     <= r_frame_sum;
                        r_out.max_time       <= {24'd0, r_frame_max};
                        r_out.units_total    <= '0;
                        r_out.elapsed_ticks  <= r_elapsed;
                        r_out.hitch_25       <= r_hitch[0];
                        r_out.hitch_50       <= r_hitch[1];
                        r_out.hitch_100      <= r_hitch[2];
                        r_out.last_of_report <= 1'b0;
                        r_idx                <= '0;
                        r_state              <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_REC;
                end
                S_REC: begin
                    if (out_free) begin
                        r_out.record_kind    <= wels_pkg::REC_PHASE;
                        r_out.phase_number   <= 6'(r_idx);
                        r_out.event_count    <= cur.calls;
                        r_out.slow_count     <= cur.slow;
                        r_out.total_time     <= cur.total;
                        r_out.max_time       <= cur.tmax;
                        r_out.units_total    <= cur.units;
                        r_out.elapsed_ticks  <= r_elapsed;
                        r_out.hitch_25       <= '0;
                        r_out.hitch_50       <= '0;
                        r_out.hitch_100      <= '0;
                        r_out.last_of_report <= (r_idx == LAST_IDX);
                        if (r_idx == LAST_IDX) begin
                            // end of report: clear stats, reopen window here
                            r_valid        <= '0;
                            r_frame_count  <= '0;
                            r_frame_sum    <= '0;
                            r_frame_max    <= '0;
                            r_hitch[0]     <= '0;
                            r_hitch[1]     <= '0;
                            r_hitch[2]     <= '0;
                            r_window_start <= r_item.now;
                            r_window_end   <= wels_pkg::sat_add48(r_item.now,
                                                                  i_report_interval);
                            r_state        <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rec.valid          = r_out_valid;
    assign o_rec.record_kind    = r_out.record_kind;
    assign o_rec.phase_number   = r_out.phase_number;
    assign o_rec.event_count    = r_out.event_count;
    assign o_rec.slow_count     = r_out.slow_count;
    assign o_rec.total_time     = r_out.total_time;
    assign o_rec.max_time       = r_out.max_time;
    assign o_rec.units_total    = r_out.units_total;
    assign o_rec.elapsed_ticks  = r_out.elapsed_ticks;
    assign o_rec.hitch_25       = r_out.hitch_25;
    assign o_rec.hitch_50       = r_out.hitch_50;
    assign o_rec.hitch_100      = r_out.hitch_100;
    assign o_rec.last_of_report = r_out.last_of_report;

endmodule
